FILE: hdl/rcc_pkg.sv
`default_nettype none

package rcc_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_FIRST_GATE   = 3'd0,
        REG_TOP_ANGLE    = 3'd1,
        REG_RANGE_STEP   = 3'd2,
        REG_ANGLE_STEP   = 3'd3,
        REG_STRAT_RADIUS = 3'd4,
        REG_CORE_RADIUS  = 3'd5,
        REG_CORE_OFFSET  = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        REGION_OUTSIDE = 2'd0,
        REGION_STRAT   = 2'd1,
        REGION_CORE    = 2'd2
    } region_t;

    // CORDIC datapath widths: x/y in 2^-17 metre, z in degrees times 2^20.
    localparam int XW = 50;
    localparam int ZW = 29;

    // Angles in 1/2048 degree.
    localparam logic [19:0] ANG_90  = 20'd184320;
    localparam logic [19:0] ANG_180 = 20'd368640;
    localparam logic [19:0] ANG_270 = 20'd552960;
    localparam logic [19:0] ANG_360 = 20'd737280;

    // CORDIC gain limit in Q30.
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // The angle modulo 360 degrees is done as the quotient by 2^14 taken modulo 45.
    // The quotient is lifted by a multiple of 45 to make it positive, then divided
    // by 45 through a reciprocal that is exact for all 24-bit values.
    localparam logic [24:0] MOD_OFFSET = 25'd5898240;
    localparam logic [26:0] MOD_RECIP  = 27'd95443718;
    localparam logic [23:0] MOD_BASE   = 24'd45;

    localparam logic signed [ZW-1:0] ATAN_Q20 [0:31] = '{
        29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
        29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
        29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
        29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
        29'sd917,      29'sd458,      29'sd229,      29'sd115,
        29'sd57,       29'sd29,       29'sd14,       29'sd7,
        29'sd4,        29'sd2,        29'sd1,        29'sd0,
        29'sd0,        29'sd0,        29'sd0,        29'sd0
    };

    typedef struct packed {
        logic signed [16:0] first_gate;
        logic signed [20:0] top_angle;
        logic        [12:0] range_step;
        logic        [13:0] angle_step;
        logic        [19:0] strat_radius;
        logic        [19:0] core_radius;
        logic signed [20:0] core_offset;
    } cfg_t;

    typedef struct packed {
        logic        [11:0] range_index;
        logic        [11:0] angle_index;
        logic signed [23:0] dx;
        logic signed [23:0] dy;
    } side_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

endpackage

`default_nettype wire

FILE: hdl/polar_grid_raincell_classify.sv
`default_nettype none

// Polar grid rain-cell classifier. Each input transfer names one cell of a
// polar radar box and the radar offset from the rain-cell centre; exactly one
// output transfer follows for each, in order, carrying the cell indices and
// its region (0 outside, 1 stratiform, 2 core). The block is a single pipeline
// that takes one cell per clock while the output is not held; an item passes
// through the front stages, one stage per CORDIC iteration and the distance
// stages. When the output is held, the whole pipeline holds and s_axis_tready
// falls in the same cycle. Configuration registers may be written only while
// no item is in flight.
module polar_grid_raincell_classify
    import rcc_pkg::*;
#(
    parameter int GRID_INDEX_BITS   = 12,
    parameter int CORDIC_ITERATIONS = 16,
    parameter int COORD_WIDTH       = 24
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tdata: range_index[11:0], angle_index[23:12], centre_dx[47:24], centre_dy[71:48]
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: range_index_out[11:0], angle_index_out[23:12], region[25:24], zero fill
    output logic [31:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [20:0] cfg_data
);

    // Only the low bits of each 12-bit index field are used.
    localparam int IDX_BITS = (GRID_INDEX_BITS < 12) ? GRID_INDEX_BITS : 12;
    localparam int N        = CORDIC_ITERATIONS;
    localparam int Z_TOL    = 2 * int'(ATAN_Q20[N-1]) + N;

    cfg_t cfg_reg;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_gate   <= '0;
            cfg_reg.top_angle    <= '0;
            cfg_reg.range_step   <= 13'd250;
            cfg_reg.angle_step   <= 14'd1024;
            cfg_reg.strat_radius <= '0;
            cfg_reg.core_radius  <= '0;
            cfg_reg.core_offset  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FIRST_GATE:   cfg_reg.first_gate   <= $signed(cfg_data[16:0]);
                REG_TOP_ANGLE:    cfg_reg.top_angle    <= $signed(cfg_data);
                REG_RANGE_STEP:   cfg_reg.range_step   <= cfg_data[12:0];
                REG_ANGLE_STEP:   cfg_reg.angle_step   <= cfg_data[13:0];
                REG_STRAT_RADIUS: cfg_reg.strat_radius <= cfg_data[19:0];
                REG_CORE_RADIUS:  cfg_reg.core_radius  <= cfg_data[19:0];
                REG_CORE_OFFSET:  cfg_reg.core_offset  <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or drained.
    logic  en;
    side_t in_side;
    logic  out_valid;
    side_t out_side;
    region_t out_region;

    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    assign in_side.range_index = s_axis_tdata[11:0];
    assign in_side.angle_index = s_axis_tdata[23:12];
    assign in_side.dx          = $signed(s_axis_tdata[47:24]);
    assign in_side.dy          = $signed(s_axis_tdata[71:48]);

    logic    cv   [0:N];
    cordic_t vec  [0:N];
    side_t   side [0:N];

    rcc_front #(
        .IDX_BITS (IDX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_side   (in_side),
        .cfg       (cfg_reg),
        .out_valid (cv[0]),
        .out_side  (side[0]),
        .out_vec   (vec[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        rcc_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cv[i]),
            .in_vec    (vec[i]),
            .in_side   (side[i]),
            .out_valid (cv[i+1]),
            .out_vec   (vec[i+1]),
            .out_side  (side[i+1])
        );
    end

    rcc_classify #(
        .CW (COORD_WIDTH)
    ) u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (cv[N]),
        .in_vec     (vec[N]),
        .in_side    (side[N]),
        .cfg        (cfg_reg),
        .out_valid  (out_valid),
        .out_side   (out_side),
        .out_region (out_region)
    );

    // The echoed indices carry only the index bits that are in use.
    logic [11:0] ri_echo;
    logic [11:0] ai_echo;

    assign ri_echo = 12'(out_side.range_index[IDX_BITS-1:0]);
    assign ai_echo = 12'(out_side.angle_index[IDX_BITS-1:0]);

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {6'd0, out_region, ai_echo, ri_echo};

    // A region code of 3 would mean the compare chain broke.
    a_region_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_region == REGION_OUTSIDE || out_region == REGION_STRAT
                           || out_region == REGION_CORE))
        else $error("illegal region code");

    // After folding, the start angle lies within plus or minus 90 degrees.
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        cv[0] |-> (vec[0].z <= ZW'($signed({1'b0, ANG_90, 9'd0}))
                   && vec[0].z >= -ZW'($signed({1'b0, ANG_90, 9'd0}))))
        else $error("folded angle out of range");

    // The CORDIC must have rotated the angle down to its last step size.
    a_cordic_converged: assert property (@(posedge clk) disable iff (!rst_n)
        cv[N] |-> (vec[N].z <= ZW'(Z_TOL) && vec[N].z >= -ZW'(Z_TOL)))
        else $error("CORDIC residual angle too large");

endmodule

`default_nettype wire

FILE: hdl/rcc_front.sv
`default_nettype none

// Forms range and angle, reduces the angle to one turn and folds it into
// the right half plane. Four register stages.
module rcc_front
    import rcc_pkg::*;
#(
    parameter int IDX_BITS = 12
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire side_t   in_side,
    input  wire cfg_t    cfg,
    output logic         out_valid,
    output side_t        out_side,
    output cordic_t      out_vec
);

    logic [3:0] valid_reg;
    side_t      side_reg [0:3];

    // Stage 1: exact range in half metres and angle in 1/2048 degree.
    logic [IDX_BITS-1:0] ri;
    logic [IDX_BITS-1:0] ai;
    logic signed [17:0]  rsum;
    logic signed [21:0]  adiff;
    logic signed [32:0]  r2_next, r2_reg;
    logic signed [37:0]  a2_next, a2_reg;

    assign ri      = in_side.range_index[IDX_BITS-1:0];
    assign ai      = in_side.angle_index[IDX_BITS-1:0];
    assign rsum    = 18'(cfg.first_gate) + 18'($signed({1'b0, ri}));
    assign adiff   = 22'(cfg.top_angle) - 22'($signed({1'b0, ai})) - 22'sd1;
    assign r2_next = $signed({rsum, 1'b1}) * $signed({1'b0, cfg.range_step});
    assign a2_next = $signed({adiff, 1'b1}) * $signed({1'b0, cfg.angle_step});

    // Stage 2: gain scaling and reciprocal multiply for the turn reduction.
    logic signed [63:0] xg_next, xg_reg;
    logic signed [24:0] nsum;
    logic [23:0]        n_next, n_reg;
    logic [50:0]        nm_next, nm_reg;
    logic [13:0]        low_reg;

    assign xg_next = r2_reg * $signed({1'b0, GAIN_Q30});
    assign nsum    = 25'($signed(a2_reg[37:14])) + $signed(MOD_OFFSET);
    assign n_next  = nsum[23:0];
    assign nm_next = 51'(n_next) * 51'(MOD_RECIP);

    // Stage 3: remainder modulo 45 gives the angle within one turn.
    logic [18:0]        qq;
    logic [23:0]        rem24;
    logic [19:0]        a2m_next, a2m_reg;
    logic signed [XW-1:0] x0_next, x0_reg;

    assign qq       = nm_reg[50:32];
    assign rem24    = n_reg - 24'(24'(qq) * MOD_BASE);
    assign a2m_next = {rem24[5:0], low_reg};
    assign x0_next  = $signed(xg_reg[63:14]);

    // Stage 4: fold into [-90, 90] degrees; a half-turn fold negates x.
    logic signed [20:0] af;
    logic               neg;
    cordic_t            vec_next, vec_reg;

    always_comb
    begin
        neg = 1'b0;
        af  = $signed({1'b0, a2m_reg});
        if (a2m_reg > ANG_90 && a2m_reg <= ANG_270)
        begin
            af  = $signed({1'b0, a2m_reg}) - $signed({1'b0, ANG_180});
            neg = 1'b1;
        end
        else if (a2m_reg > ANG_270)
        begin
            af = $signed({1'b0, a2m_reg}) - $signed({1'b0, ANG_360});
        end
        vec_next.x = neg ? -x0_reg : x0_reg;
        vec_next.y = '0;
        vec_next.z = ZW'($signed({af, 9'd0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
            r2_reg      <= r2_next;
            a2_reg      <= a2_next;
            xg_reg      <= xg_next;
            n_reg       <= n_next;
            nm_reg      <= nm_next;
            low_reg     <= a2_reg[13:0];
            a2m_reg     <= a2m_next;
            x0_reg      <= x0_next;
            vec_reg     <= vec_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_side  = side_reg[3];
    assign out_vec   = vec_reg;

endmodule

`default_nettype wire

FILE: hdl/rcc_cordic_stage.sv
`default_nettype none

// One rotation-mode CORDIC iteration with its output register.
module rcc_cordic_stage
    import rcc_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire cordic_t in_vec,
    input  wire side_t   in_side,
    output logic         out_valid,
    output cordic_t      out_vec,
    output side_t        out_side
);

    logic                 valid_reg;
    cordic_t              vec_next, vec_reg;
    side_t                side_reg;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign xs = in_vec.x >>> STAGE;
    assign ys = in_vec.y >>> STAGE;

    always_comb
    begin
        if (!in_vec.z[ZW-1])
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ATAN_Q20[STAGE];
        end
        else
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ATAN_Q20[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

FILE: hdl/rcc_classify.sv
`default_nettype none

// Rounds the CORDIC result to metres, offsets it by the cell centre and
// compares squared distances. Six register stages, the last is the output.
module rcc_classify
    import rcc_pkg::*;
#(
    parameter int CW = 24
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    en,
    input  wire logic    in_valid,
    input  wire cordic_t in_vec,
    input  wire side_t   in_side,
    input  wire cfg_t    cfg,
    output logic         out_valid,
    output side_t        out_side,
    output region_t      out_region
);

    localparam int RXW = ((CW > 24) ? CW : 24) + 1;
    localparam int CXW = RXW + 1;
    localparam int K   = (CXW + 1) / 2;
    localparam int HW  = CXW - K;
    localparam int SQW = 2 * CXW;
    localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] LIM_LO = -(64'sd1 <<< (CW - 1));

    logic [5:0] valid_reg;
    side_t      side_reg [0:5];

    // Stage 1: round to nearest metre and saturate.
    logic signed [XW-1:0] xr, yr;
    logic signed [63:0]   mx, my;
    logic signed [CW-1:0] px_next, px_reg, py_next, py_reg;

    assign xr = in_vec.x + XW'(65536);
    assign yr = in_vec.y + XW'(65536);
    assign mx = 64'($signed(xr[XW-1:17]));
    assign my = 64'($signed(yr[XW-1:17]));

    always_comb
    begin
        priority if (mx > LIM_HI)
            px_next = CW'(LIM_HI);
        else if (mx < LIM_LO)
            px_next = CW'(LIM_LO);
        else
            px_next = CW'(mx);
        priority if (my > LIM_HI)
            py_next = CW'(LIM_HI);
        else if (my < LIM_LO)
            py_next = CW'(LIM_LO);
        else
            py_next = CW'(my);
    end

    // Stage 2: position relative to the cell centre and to the core centre.
    logic signed [RXW-1:0] rx_next, rx_reg, ry_next, ry_reg;
    logic signed [CXW-1:0] cx_next, cx_reg;

    assign rx_next = RXW'(side_reg[0].dx) + RXW'(px_reg);
    assign ry_next = RXW'(side_reg[0].dy) + RXW'(py_reg);
    assign cx_next = CXW'(side_reg[0].dx) + CXW'(px_reg) + CXW'(cfg.core_offset);

    // Stage 3: magnitudes; entry 0 is rx, 1 is ry, 2 is the core x.
    logic signed [CXW-1:0] sv [0:2];
    logic [CXW-1:0]        mag_next [0:2];
    logic [CXW-1:0]        mag_reg  [0:2];

    assign sv[0] = CXW'(rx_reg);
    assign sv[1] = CXW'(ry_reg);
    assign sv[2] = cx_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            mag_next[j] = sv[j][CXW-1] ? CXW'(-sv[j]) : CXW'(sv[j]);
        end
    end

    // Stage 4: partial products of the squares, and the squared radii.
    logic [2*HW-1:0]  hh_reg [0:2];
    logic [HW+K-1:0]  hl_reg [0:2];
    logic [2*K-1:0]   ll_reg [0:2];
    logic [39:0]      s2_reg, c2_reg;

    // Stage 5: squares.
    logic [SQW-1:0]   sq_next [0:2];
    logic [SQW-1:0]   sq_reg  [0:2];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sq_next[j] = (SQW'(hh_reg[j]) << (2 * K)) + (SQW'(hl_reg[j]) << (K + 1))
                       + SQW'(ll_reg[j]);
        end
    end

    // Stage 6: sums and compares.
    logic [SQW:0] d2, cd2;
    region_t      region_next, region_reg;

    assign d2  = (SQW + 1)'(sq_reg[0]) + (SQW + 1)'(sq_reg[1]);
    assign cd2 = (SQW + 1)'(sq_reg[2]) + (SQW + 1)'(sq_reg[1]);

    always_comb
    begin
        priority if (d2 > (SQW + 1)'(s2_reg))
            region_next = REGION_OUTSIDE;
        else if (cd2 <= (SQW + 1)'(c2_reg))
            region_next = REGION_CORE;
        else
            region_next = REGION_STRAT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < 6; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            px_reg <= px_next;
            py_reg <= py_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            cx_reg <= cx_next;
            for (int j = 0; j < 3; j++)
            begin
                mag_reg[j] <= mag_next[j];
                hh_reg[j]  <= (2*HW)'(mag_reg[j][CXW-1:K]) * (2*HW)'(mag_reg[j][CXW-1:K]);
                hl_reg[j]  <= (HW+K)'(mag_reg[j][CXW-1:K]) * (HW+K)'(mag_reg[j][K-1:0]);
                ll_reg[j]  <= (2*K)'(mag_reg[j][K-1:0]) * (2*K)'(mag_reg[j][K-1:0]);
                sq_reg[j]  <= sq_next[j];
            end
            s2_reg     <= 40'(cfg.strat_radius) * 40'(cfg.strat_radius);
            c2_reg     <= 40'(cfg.core_radius) * 40'(cfg.core_radius);
            region_reg <= region_next;
        end
    end

    assign out_valid  = valid_reg[5];
    assign out_side   = side_reg[5];
    assign out_region = region_reg;

endmodule

`default_nettype wire

FILE: tb/rcc_checker.sv
`default_nettype none

// Watches both streams, predicts the region of each accepted cell and
// compares it with the output transfers, oldest first.
module rcc_checker
    import rcc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [31:0] m_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [20:0] cfg_data,
    output int               fail_count,
    output int               pending_count
);

    localparam int ITER = 16;

    // Laid out as on the output tdata, lowest field last.
    typedef struct packed {
        logic [1:0]  region;
        logic [11:0] angle_index;
        logic [11:0] range_index;
    } cell_result_t;

    cfg_t         shadow_cfg;
    cell_result_t region_queue[$];

    assign pending_count = region_queue.size();

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_metres(longint v);
        longint m;
        longint lim;
        lim = (64'sd1 <<< 23) - 1;
        m = floor_shift(v + (64'sd1 <<< 16), 17);
        if (m > lim) m = lim;
        if (m < -lim - 1) m = -lim - 1;
        return m;
    endfunction

    function automatic cell_result_t classify_cell(logic [71:0] d);
        longint ri, ai, cdx, cdy, r2, a2, x, y, z, xs, ys, rx, ry, cx, d2, c2, s, c;
        bit flip;
        cell_result_t res;
        ri = d[11:0];
        ai = d[23:12];
        cdx = longint'($signed(d[47:24]));
        cdy = longint'($signed(d[71:48]));
        r2 = (2 * (longint'(shadow_cfg.first_gate) + ri) + 1) * longint'(shadow_cfg.range_step);
        a2 = (2 * (longint'(shadow_cfg.top_angle) - ai) - 1) * longint'(shadow_cfg.angle_step);
        flip = 0;
        a2 = a2 % 737280;
        if (a2 < 0) a2 += 737280;
        if (a2 > 184320 && a2 <= 552960) begin
            a2 -= 368640;
            flip = 1;
        end else if (a2 > 552960) begin
            a2 -= 737280;
        end
        x = floor_shift(r2 * 652032874, 14);
        if (flip) x = -x;
        y = 0;
        z = a2 * 512;
        for (int i = 0; i < ITER; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= longint'(ATAN_Q20[i]);
            end else begin
                x += ys;
                y -= xs;
                z += longint'(ATAN_Q20[i]);
            end
        end
        rx = cdx + round_metres(x);
        ry = cdy + round_metres(y);
        cx = rx + longint'(shadow_cfg.core_offset);
        d2 = rx * rx + ry * ry;
        c2 = cx * cx + ry * ry;
        s = longint'(shadow_cfg.strat_radius) * longint'(shadow_cfg.strat_radius);
        c = longint'(shadow_cfg.core_radius) * longint'(shadow_cfg.core_radius);
        res.range_index = d[11:0];
        res.angle_index = d[23:12];
        if (d2 > s)
            res.region = REGION_OUTSIDE;
        else if (c2 <= c)
            res.region = REGION_CORE;
        else
            res.region = REGION_STRAT;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t want;
        cell_result_t got;
        if (!rst_n)
        begin
            shadow_cfg <= '{first_gate: '0, top_angle: '0, range_step: 13'd250,
                            angle_step: 14'd1024, strat_radius: '0, core_radius: '0,
                            core_offset: '0};
            fail_count <= 0;
            region_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_FIRST_GATE:   shadow_cfg.first_gate   <= cfg_data[16:0];
                    REG_TOP_ANGLE:    shadow_cfg.top_angle    <= cfg_data[20:0];
                    REG_RANGE_STEP:   shadow_cfg.range_step   <= cfg_data[12:0];
                    REG_ANGLE_STEP:   shadow_cfg.angle_step   <= cfg_data[13:0];
                    REG_STRAT_RADIUS: shadow_cfg.strat_radius <= cfg_data[19:0];
                    REG_CORE_RADIUS:  shadow_cfg.core_radius  <= cfg_data[19:0];
                    REG_CORE_OFFSET:  shadow_cfg.core_offset  <= cfg_data[20:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                region_queue.push_back(classify_cell(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[25:0];
                if (region_queue.size() == 0)
                begin
                    $display("%0t: output transfer with none expected, actual %h",
                             $time, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = region_queue.pop_front();
                    if (got !== want || m_axis_tdata[31:26] !== 6'd0)
                    begin
                        $display("%0t: mismatch expected ri=%0d ai=%0d region=%0d, actual ri=%0d ai=%0d region=%0d pad=%h",
                                 $time, want.range_index, want.angle_index, want.region,
                                 got.range_index, got.angle_index, got.region,
                                 m_axis_tdata[31:26]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

// Stimulus and verdict for the rain-cell classifier. The configuration is
// changed between phases, only once the pipeline has drained; each random
// phase sends a mix of cells chosen to land in reach of the configured radii
// and cells with fully random offsets.
module tb;
    import rcc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [20:0] cfg_data;
    int          fail_count;
    int          pending_count;

    // Idling on both sides is switched off near the end of the run.
    bit          calm;

    polar_grid_raincell_classify u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    rcc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The receiver stalls in random bursts while idling is allowed.
    initial
    begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // One register write; the enable goes low again before the next one.
    task automatic write_reg(reg_index_t idx, logic [20:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // One cell transfer, with a random gap before it while idling is allowed.
    task automatic send_cell(logic [11:0] ri, logic [11:0] ai, logic [23:0] dx,
                             logic [23:0] dy);
        int gap;
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {dy, dx, ai, ri};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // A random cell whose offset puts it in reach of the configured radii most
    // of the time, so that all three regions show up.
    task automatic send_random_cell(int radius);
        logic [11:0] ri;
        logic [11:0] ai;
        int          spread;
        ri = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 40));
        ai = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 40));
        spread = radius * 2 + 2000;
        if ($urandom_range(0, 4) == 0)
            send_cell(ri, ai, 24'($urandom), 24'($urandom));
        else
            send_cell(ri, ai, 24'($urandom_range(0, 2 * spread) - spread),
                      24'($urandom_range(0, 2 * spread) - spread));
    endtask

    initial
    begin
        int radius;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        calm          = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: zero radii, so only a cell at the exact centre
        // counts as inside.
        send_cell(12'd0, 12'd0, 24'd0, 24'd0);
        send_cell(12'hFFF, 12'hFFF, 24'h7FFFFF, 24'h800000);
        send_cell(12'd0, 12'd0, -24'sd125, 24'd0);
        drain_pipeline();

        // Directed: field extremes, negative range, zero steps, all regions.
        write_reg(REG_FIRST_GATE, 21'h10000);
        write_reg(REG_TOP_ANGLE, 21'h0FFFFF);
        write_reg(REG_RANGE_STEP, 21'd4096);
        write_reg(REG_ANGLE_STEP, 21'd10240);
        write_reg(REG_STRAT_RADIUS, 21'hFFFFF);
        write_reg(REG_CORE_RADIUS, 21'd500000);
        write_reg(REG_CORE_OFFSET, 21'h100000);
        send_cell(12'd0, 12'd0, 24'd0, 24'd0);
        send_cell(12'hFFF, 12'hFFF, 24'h800000, 24'h7FFFFF);
        send_cell(12'hAAA, 12'h555, 24'h555555, 24'hAAAAAA);
        send_cell(12'h555, 12'hAAA, 24'hAAAAAA, 24'h555555);
        drain_pipeline();
        write_reg(REG_RANGE_STEP, 21'd0);
        write_reg(REG_ANGLE_STEP, 21'd0);
        write_reg(REG_CORE_OFFSET, 21'h0FFFFF);
        send_cell(12'd7, 12'd9, 24'd1000, -24'sd1000);
        send_cell(12'd0, 12'd0, 24'd0, 24'd0);
        drain_pipeline();

        // Random phases with a fresh configuration each.
        for (int phase = 0; phase < 13; phase++)
        begin
            radius = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1048575)
                                                : $urandom_range(0, 60000);
            write_reg(REG_FIRST_GATE, 21'($urandom_range(0, 5) == 0 ? $urandom
                                          : $urandom_range(0, 200) - 100));
            write_reg(REG_TOP_ANGLE, 21'($urandom_range(0, 5) == 0 ? $urandom
                                         : $urandom_range(0, 720) - 360));
            write_reg(REG_RANGE_STEP, 21'($urandom_range(1, 4096)));
            write_reg(REG_ANGLE_STEP, 21'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
                                          : $urandom_range(1, 10240)));
            write_reg(REG_STRAT_RADIUS, 21'(radius));
            write_reg(REG_CORE_RADIUS, 21'($urandom_range(0, radius)));
            write_reg(REG_CORE_OFFSET, 21'($urandom_range(0, 3) == 0 ? $urandom
                                           : $urandom_range(0, radius / 2 + 1) - radius / 4));
            if (phase == 11)
                calm = 1'b1;
            for (int n = 0; n < 150; n++)
                send_random_cell(radius);
            drain_pipeline();
        end

        if (fail_count == 0)
            $display("** polar_grid_raincell_classify: PASSED **");
        else
            $display("** polar_grid_raincell_classify: FAILED **");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("** polar_grid_raincell_classify: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
